// ===== hw/rtl/ulr_pkg.sv =====
// Shared types and constants for the UART-lite register block.
// No dependencies; used by the interfaces and every module under hw/rtl.

package ulr_pkg;

    localparam int ADDR_W = 32;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;

    // Item kinds
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_RX    = 2'd2;

    // Register offsets from the base address
    localparam logic [ADDR_W-1:0] OFS_RX_FIFO = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] OFS_TX_FIFO = 32'h0000_0004;
    localparam logic [ADDR_W-1:0] OFS_STATUS  = 32'h0000_0008;
    localparam logic [ADDR_W-1:0] OFS_CTRL    = 32'h0000_000c;

    // Control register bits
    localparam int CTRL_RX_RST_BIT = 1;
    localparam int CTRL_IRQ_EN_BIT = 4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ADDR_W-1:0] bus_address;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              bad_offset;
        logic              rx_dropped;
    } out_item_t;

    // Requests from the decoder to the receive FIFO
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [BYTE_W-1:0] push_byte;
    } fifo_ctrl_t;

    // FIFO status as seen by the decoder
    typedef struct packed {
        logic              not_empty;
        logic              full;
        logic [BYTE_W-1:0] head_byte;
    } fifo_stat_t;

endpackage

// ===== hw/rtl/ulr_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on ulr_pkg for field widths.

interface ulr_in_if;
    logic                          valid;
    logic                          ready;
    logic [ulr_pkg::OP_W-1:0]      opcode;
    logic [ulr_pkg::ADDR_W-1:0]    bus_address;
    logic [ulr_pkg::BYTE_W-1:0]    write_data;
    logic [ulr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output opcode, output bus_address,
                    output write_data, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input bus_address,
                    input write_data, input rx_byte, output ready);
endinterface

interface ulr_out_if;
    logic                          valid;
    logic                          ready;
    logic [ulr_pkg::BYTE_W-1:0]    read_data;
    logic                          tx_valid;
    logic [ulr_pkg::BYTE_W-1:0]    tx_byte;
    logic                          bad_offset;
    logic                          rx_dropped;

    modport source (output valid, output read_data, output tx_valid,
                    output tx_byte, output bad_offset, output rx_dropped,
                    input ready);
    modport sink   (input valid, input read_data, input tx_valid,
                    input tx_byte, input bad_offset, input rx_dropped,
                    output ready);
endinterface

// ===== hw/rtl/ulr_rx_fifo.sv =====
// Receive FIFO: byte store, head/tail pointers, fill count, prefetched head byte.
// Depends on ulr_pkg for the control and status structs.

module ulr_rx_fifo #(
    parameter int RX_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ulr_pkg::fifo_ctrl_t ctrl,
    output ulr_pkg::fifo_stat_t stat
);

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CNT_W = $clog2(RX_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RX_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RX_DEPTH);

    logic [ulr_pkg::BYTE_W-1:0] store_mem [RX_DEPTH];
    logic [ulr_pkg::BYTE_W-1:0] head_byte_reg;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [CNT_W-1:0]           count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (ctrl.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        else if (ctrl.push)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The head byte is prefetched into a register from the next head pointer; a push
    // into an empty FIFO lands on the next head and is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store_mem[tail_reg] <= ctrl.push_byte;
        end
        if (ctrl.push && (tail_reg == head_next))
        begin
            head_byte_reg <= ctrl.push_byte;
        end
        else
        begin
            head_byte_reg <= store_mem[head_next];
        end
    end

    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == FULL_CNT);
    assign stat.head_byte = head_byte_reg;

endmodule

// ===== hw/rtl/ulr_decode.sv =====
// Register decode and result formation for one item.
// Depends on ulr_pkg for item structs, offsets and opcodes.

module ulr_decode (
    input  ulr_pkg::in_item_t                item,
    input  logic [ulr_pkg::ADDR_W-1:0]       base_address,
    input  ulr_pkg::fifo_stat_t              fifo_stat,
    input  logic                             irq_en,
    output ulr_pkg::out_item_t               result,
    output ulr_pkg::fifo_ctrl_t              fifo_ctrl,
    output logic                             irq_we,
    output logic                             irq_en_next
);

    logic [ulr_pkg::ADDR_W-1:0] offset;

    assign offset = item.bus_address - base_address;

    always_comb
    begin
        result              = '0;
        fifo_ctrl           = '0;
        fifo_ctrl.push_byte = item.rx_byte;
        irq_we              = 1'b0;
        irq_en_next         = item.write_data[ulr_pkg::CTRL_IRQ_EN_BIT];

        unique case (item.opcode)
            ulr_pkg::OP_READ:
            begin
                if (offset == ulr_pkg::OFS_RX_FIFO)
                begin
                    if (fifo_stat.not_empty)
                    begin
                        result.read_data = fifo_stat.head_byte;
                        fifo_ctrl.pop    = 1'b1;
                    end
                end
                else if (offset == ulr_pkg::OFS_STATUS)
                begin
                    // irq enable, tx full (never), tx empty (always), rx full, rx valid
                    result.read_data = {3'b000, irq_en, 1'b0, 1'b1,
                                        fifo_stat.full, fifo_stat.not_empty};
                end
                else
                begin
                    result.bad_offset = 1'b1;
                end
            end
            ulr_pkg::OP_WRITE:
            begin
                if (offset == ulr_pkg::OFS_TX_FIFO)
                begin
                    result.tx_valid = 1'b1;
                    result.tx_byte  = item.write_data;
                end
                else if (offset == ulr_pkg::OFS_CTRL)
                begin
                    fifo_ctrl.clear = item.write_data[ulr_pkg::CTRL_RX_RST_BIT];
                    irq_we          = 1'b1;
                end
                else
                begin
                    result.bad_offset = 1'b1;
                end
            end
            ulr_pkg::OP_RX:
            begin
                if (fifo_stat.full)
                begin
                    result.rx_dropped = 1'b1;
                end
                else
                begin
                    fifo_ctrl.push = 1'b1;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/uart_lite_register_model.sv =====
// Top level of the UART-lite register block: input register, decode, result register.
// Depends on ulr_pkg, ulr_if, ulr_rx_fifo and ulr_decode.
//
// Each request item is a bus read, a bus write, or a byte arriving from the line,
// and yields exactly one response item. An item is captured in an input register;
// once the output register is free or being taken, it is decoded, applied to the
// receive FIFO and control state, and its response is loaded into that register.
// One item is accepted every cycle as long as the response side keeps up; the FIFO
// pointers and the prefetched head byte are updated together with each item, which
// sets that rate. The user must write the base address through cfg_we/cfg_wdata
// only while no items are in flight; the block does not enforce this. Reads of
// offset 0 pop the receive FIFO (RX_DEPTH entries), offset 8 returns status, writes
// to offset 4 transmit at once and writes to offset 0xc control rx reset and
// interrupt enable.

module uart_lite_register_model #(
    parameter int RX_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ulr_pkg::ADDR_W-1:0] cfg_wdata,
    ulr_in_if.sink                     req,
    ulr_out_if.source                  rsp
);

    logic [ulr_pkg::ADDR_W-1:0] base_reg;
    logic                       irq_en_reg;
    logic                       item_valid_reg;
    ulr_pkg::in_item_t          item_reg;
    logic                       rsp_valid_reg;
    ulr_pkg::out_item_t         rsp_reg;

    ulr_pkg::out_item_t         result;
    ulr_pkg::fifo_ctrl_t        ctrl_raw;
    ulr_pkg::fifo_ctrl_t        fifo_ctrl;
    ulr_pkg::fifo_stat_t        fifo_stat;
    logic                       irq_we;
    logic                       irq_en_next;
    logic                       advance;
    logic                       fire;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = item_valid_reg && advance;
    assign req.ready = !item_valid_reg || advance;

    assign fifo_ctrl.push      = ctrl_raw.push && fire;
    assign fifo_ctrl.pop       = ctrl_raw.pop && fire;
    assign fifo_ctrl.clear     = ctrl_raw.clear && fire;
    assign fifo_ctrl.push_byte = ctrl_raw.push_byte;

    ulr_decode u_decode (
        .item         (item_reg),
        .base_address (base_reg),
        .fifo_stat    (fifo_stat),
        .irq_en       (irq_en_reg),
        .result       (result),
        .fifo_ctrl    (ctrl_raw),
        .irq_we       (irq_we),
        .irq_en_next  (irq_en_next)
    );

    ulr_rx_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            irq_en_reg     <= 1'b0;
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (fire && irq_we)
            begin
                irq_en_reg <= irq_en_next;
            end
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.opcode      <= req.opcode;
            item_reg.bus_address <= req.bus_address;
            item_reg.write_data  <= req.write_data;
            item_reg.rx_byte     <= req.rx_byte;
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = rsp_reg.read_data;
    assign rsp.tx_valid   = rsp_reg.tx_valid;
    assign rsp.tx_byte    = rsp_reg.tx_byte;
    assign rsp.bad_offset = rsp_reg.bad_offset;
    assign rsp.rx_dropped = rsp_reg.rx_dropped;

`ifndef SYNTH
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctrl.pop |-> fifo_stat.not_empty)
        else $error("rx pop while FIFO empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctrl.push |-> !fifo_stat.full)
        else $error("rx push while FIFO full");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctrl.clear |=> !fifo_stat.not_empty)
        else $error("rx FIFO not empty after clear");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> $countones({rsp_reg.tx_valid, rsp_reg.bad_offset,
                                      rsp_reg.rx_dropped}) <= 1)
        else $error("response flags more than one event");
`endif

endmodule
